/* rtl/cee_pkg.sv */
// shared types, constants and helpers of the chebyshev ephemeris evaluator
// no dependencies; imported by every module of the block
package cee_pkg;

    localparam int MAX_COEFF_DEF   = 16;
    localparam int MAX_RECORDS_DEF = 1024;

    localparam int REC_W      = 10;
    localparam int WORD_W     = 6;
    localparam int VAL_W      = 64;
    localparam int ACC_W      = 72;
    localparam int CFG_ADDR_W = 2;
    localparam int DIV_CNT_W  = 7;
    localparam int NUM_W      = 126;

    localparam logic [DIV_CNT_W-1:0] IDX_STEPS  = 7'd64;
    localparam logic [DIV_CNT_W-1:0] NORM_STEPS = 7'd126;

    localparam logic [63:0] Q61_ONE = 64'h2000_0000_0000_0000;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_TIME   = 2'd0,
        CFG_RECORD_SPAN  = 2'd1,
        CFG_COEFF_COUNT  = 2'd2,
        CFG_RECORD_COUNT = 2'd3
    } cfg_addr_t;

    // one record word write request into the store
    typedef struct packed {
        logic              en;
        logic [REC_W-1:0]  rec;
        logic [WORD_W-1:0] word;
        logic [VAL_W-1:0]  data;
    } store_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDX_START,
        ST_IDX_WAIT,
        ST_NORM_START,
        ST_NORM_WAIT,
        ST_T_MUL,
        ST_T_WAIT,
        ST_C_RD,
        ST_C_MUL,
        ST_C_WAIT,
        ST_DONE
    } state_t;

    // saturate a signed 128 bit value to 64 bits
    function automatic logic [63:0] sat64(input logic [127:0] v);
        if (v[127:63] == {65{1'b0}} || v[127:63] == {65{1'b1}})
            return v[63:0];
        else if (v[127])
            return S64_MIN;
        else
            return S64_MAX;
    endfunction

endpackage

/* rtl/cee_store.sv */
// record store: midpoint/half span memory and coefficient memory
// depends on cee_pkg; one write port and registered reads
module cee_store
    import cee_pkg::*;
#(
    parameter int MAX_COEFF   = MAX_COEFF_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int REC_WORDS  = 3 * MAX_COEFF,
    localparam int RA_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int CA_W       = $clog2(MAX_RECORDS * REC_WORDS)
) (
    input  logic            aclk,
    input  store_wr_t       wr,
    input  logic            rec_rd_en,
    input  logic [RA_W-1:0] rec_rd_addr,
    output logic [63:0]     mid_q,
    output logic [63:0]     half_q,
    input  logic            coef_rd_en,
    input  logic [CA_W-1:0] coef_rd_addr,
    output logic [63:0]     coef_q
);

    logic [127:0] rec_mem [MAX_RECORDS];
    logic [63:0]  coef_mem [MAX_RECORDS * REC_WORDS];

    logic [127:0]    rec_q_reg;
    logic [63:0]     coef_q_reg;
    logic            rec_ok;
    logic            coef_ok;
    logic [31:0]     woff;
    logic [RA_W-1:0] wr_rec_addr;
    logic [CA_W-1:0] wr_coef_addr;

    // address decode of a write request
    always_comb begin
        rec_ok       = 32'(wr.rec) < 32'(MAX_RECORDS);
        woff         = 32'(wr.word) - 32'd2;
        coef_ok      = (wr.word >= WORD_W'(2)) && (woff < 32'(REC_WORDS));
        wr_rec_addr  = RA_W'(wr.rec);
        wr_coef_addr = CA_W'(32'(wr.rec) * 32'(REC_WORDS) + woff);
    end

    // record memory with two 64 bit lanes
    always_ff @(posedge aclk) begin
        if (wr.en && rec_ok && wr.word == WORD_W'(0))
            rec_mem[wr_rec_addr][63:0] <= wr.data;
        if (wr.en && rec_ok && wr.word == WORD_W'(1))
            rec_mem[wr_rec_addr][127:64] <= wr.data;
        if (rec_rd_en)
            rec_q_reg <= rec_mem[rec_rd_addr];
    end

    // coefficient memory
    always_ff @(posedge aclk) begin
        if (wr.en && rec_ok && coef_ok)
            coef_mem[wr_coef_addr] <= wr.data;
        if (coef_rd_en)
            coef_q_reg <= coef_mem[coef_rd_addr];
    end

    assign mid_q  = rec_q_reg[63:0];
    assign half_q = rec_q_reg[127:64];
    assign coef_q = coef_q_reg;

endmodule

/* rtl/cee_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on cee_pkg; used for the record index and the time normalization
module cee_div
    import cee_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DIV_CNT_W-1:0] steps,
    input  logic [63:0]          divisor,
    output logic                 done,
    output logic [63:0]          q,
    output logic                 big
);

    logic [NUM_W-1:0]     num_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          div_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          q_reg;
    logic                 big_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [64:0] rem_sh;
    logic [64:0] rem_diff;
    logic        ge;
    logic [63:0] rem_next;
    logic [63:0] q_next;

    // one restoring step
    always_comb begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, div_reg};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? rem_diff[63:0] : rem_sh[63:0];
        q_next   = {q_reg[62:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            cnt_reg <= steps;
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
        end else if (busy_reg && cnt_reg != '0) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            big_reg <= big_reg | q_reg[63];
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign big  = big_reg;

endmodule

/* rtl/cee_mul.sv */
// shared signed 64x64 multiplier, four 32x32 partial products over cycles
// depends on cee_pkg; full 128 bit product is valid while done is high
module cee_mul
    import cee_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] p
);

    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // partial product selected by the step
    always_comb begin
        a_part = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_part = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp     = a_part * b_part;
        case (step_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == 3'd4) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // magnitude accumulate, then sign fix
    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg   <= a[63] ? (64'd0 - a) : a;
            mb_reg   <= b[63] ? (64'd0 - b) : b;
            neg_reg  <= a[63] ^ b[63];
            acc_reg  <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg != 3'd4) begin
                acc_reg  <= acc_reg + pp_sh;
                step_reg <= step_reg + 1'b1;
            end else if (neg_reg) begin
                acc_reg <= 128'd0 - acc_reg;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* rtl/chebyshev_ephemeris_evaluator.sv */
// chebyshev ephemeris evaluator: record store, shared divider and multiplier
// a load request is written into the store as it is accepted; a query for n coefficients
// runs on the bit-serial divider (64 + 126 steps) and the shared multiplier (n-2
// recurrence steps plus 3n terms)
// a query result waits in an output register while the next request enters
// aresetn clears control state and sets configuration to its reset values
module chebyshev_ephemeris_evaluator
    import cee_pkg::*;
#(
    parameter int MAX_COEFF   = MAX_COEFF_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // record_index[9:0], word_index[15:10], word_value[79:16], query_time[143:80]
    input  logic [143:0]          s_tdata,
    // op[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_x[63:0], pos_y[127:64], pos_z[191:128]
    output logic [191:0]          m_tdata,
    // out_of_range[0]
    output logic                  m_tuser
);

    localparam int REC_WORDS = 3 * MAX_COEFF;
    localparam int RA_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CA_W      = $clog2(MAX_RECORDS * REC_WORDS);
    localparam int KW        = $clog2(MAX_COEFF + 1);
    localparam int KI        = $clog2(MAX_COEFF);

    // configuration
    logic [63:0] start_time_reg;
    logic [62:0] record_span_reg;
    logic [4:0]  coeff_count_reg;
    logic [10:0] record_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg   <= 64'd0;
            record_span_reg  <= 63'd1;
            coeff_count_reg  <= 5'd2;
            record_count_reg <= 11'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_START_TIME:   start_time_reg   <= cfg_wdata;
                CFG_RECORD_SPAN:  record_span_reg  <= cfg_wdata[62:0];
                CFG_COEFF_COUNT:  coeff_count_reg  <= cfg_wdata[4:0];
                CFG_RECORD_COUNT: record_count_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // state and datapath registers
    state_t          state_reg, state_next;
    logic [63:0]     t_reg;
    logic [64:0]     d_reg;
    logic [RA_W-1:0] idx_reg;
    logic [KW-1:0]   n_reg;
    logic [KW-1:0]   k_reg;
    logic [1:0]      a_reg;
    logic [CA_W-1:0] ptr_reg;
    logic [63:0]     x_reg;
    logic [63:0]     t1_reg;
    logic [63:0]     t2_reg;
    logic [63:0]     t_arr [MAX_COEFF];
    logic [ACC_W-1:0] acc_reg;
    logic [63:0]     px_reg, py_reg, pz_reg;
    logic            oor_reg;
    logic            m_valid_reg;
    logic [191:0]    m_data_reg;
    logic            m_user_reg;

    // unit connections
    store_wr_t       wr;
    logic            rec_rd_en;
    logic [63:0]     mid_q, half_q, coef_q;
    logic            coef_rd_en;
    logic            div_start, div_done, div_big;
    logic [NUM_W-1:0] div_num;
    logic [DIV_CNT_W-1:0] div_steps;
    logic [63:0]     div_divisor, div_q;
    logic            mul_start, mul_done;
    logic [63:0]     mul_a, mul_b;
    logic [127:0]    mul_p;

    logic            in_acc;
    logic            is_query;
    logic [63:0]     bound64;
    logic [31:0]     n_int;
    logic [64:0]     dn;
    logic [64:0]     dabs;
    logic            nneg;
    logic [63:0]     habs;
    logic [63:0]     lim;
    logic [63:0]     qsat;
    logic [127:0]    two_x_t;
    logic [63:0]     tn;
    logic [ACC_W-1:0] term_v;
    logic [ACC_W-1:0] sum_v;
    logic [63:0]     sum_sat;
    logic            last_k;
    logic            out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_query = s_tuser;

    // load request into the store
    always_comb begin
        wr.en   = in_acc && !is_query;
        wr.rec  = s_tdata[9:0];
        wr.word = s_tdata[15:10];
        wr.data = s_tdata[79:16];
    end

    // helper arithmetic
    always_comb begin
        n_int = (coeff_count_reg < 5'd2) ? 32'd2 :
                ((32'(coeff_count_reg) > 32'(MAX_COEFF)) ? 32'(MAX_COEFF) :
                 32'(coeff_count_reg));
        bound64 = (32'(record_count_reg) < 32'(MAX_RECORDS)) ?
                  64'(record_count_reg) : 64'(MAX_RECORDS);
        dn      = {t_reg[63], t_reg} - {mid_q[63], mid_q};
        dabs    = dn[64] ? (65'd0 - dn) : dn;
        nneg    = dn[64] ^ half_q[63];
        habs    = half_q[63] ? (64'd0 - half_q) : half_q;
        lim     = oor_reg ? S64_MIN : S64_MAX;
        qsat    = (div_big || div_q > lim) ? lim : div_q;
        two_x_t = 128'($signed(mul_p) >>> 60);
        tn      = sat64(two_x_t - {{64{t2_reg[63]}}, t2_reg});
        term_v  = ACC_W'($signed(mul_p[127:61]));
        sum_v   = acc_reg + term_v;
        sum_sat = sat64(128'($signed(sum_v)));
        last_k  = (k_reg == n_reg - 1'b1);
        out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    // next state and unit strobes
    always_comb begin
        state_next  = state_reg;
        rec_rd_en   = 1'b0;
        coef_rd_en  = 1'b0;
        div_start   = 1'b0;
        div_num     = {d_reg[63:0], 62'd0};
        div_steps   = IDX_STEPS;
        div_divisor = {1'b0, record_span_reg};
        mul_start   = 1'b0;
        mul_a       = x_reg;
        mul_b       = t1_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && is_query)
                    state_next = ST_IDX_START;
            end
            ST_IDX_START: begin
                if (d_reg[64] || record_span_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_IDX_WAIT;
                end
            end
            ST_IDX_WAIT: begin
                if (div_done) begin
                    if (div_q >= bound64) begin
                        state_next = ST_DONE;
                    end else begin
                        rec_rd_en  = 1'b1;
                        state_next = ST_NORM_START;
                    end
                end
            end
            ST_NORM_START: begin
                div_num     = {dabs, 61'd0};
                div_steps   = NORM_STEPS;
                div_divisor = habs;
                if (habs == '0) begin
                    state_next = ST_T_MUL;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_NORM_WAIT;
                end
            end
            ST_NORM_WAIT: begin
                if (div_done)
                    state_next = ST_T_MUL;
            end
            ST_T_MUL: begin
                if (k_reg >= n_reg) begin
                    state_next = ST_C_RD;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_T_WAIT;
                end
            end
            ST_T_WAIT: begin
                if (mul_done)
                    state_next = ST_T_MUL;
            end
            ST_C_RD: begin
                coef_rd_en = 1'b1;
                state_next = ST_C_MUL;
            end
            ST_C_MUL: begin
                mul_a      = coef_q;
                mul_b      = t_arr[k_reg[KI-1:0]];
                mul_start  = 1'b1;
                state_next = ST_C_WAIT;
            end
            ST_C_WAIT: begin
                if (mul_done)
                    state_next = (last_k && a_reg == 2'd2) ? ST_DONE : ST_C_RD;
            end
            ST_DONE: begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // query datapath; oor_reg doubles as the sign of x during normalization
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                t_reg   <= s_tdata[143:80];
                d_reg   <= {s_tdata[143], s_tdata[143:80]} -
                           {start_time_reg[63], start_time_reg};
                n_reg   <= KW'(n_int);
                oor_reg <= 1'b1;
                px_reg  <= '0;
                py_reg  <= '0;
                pz_reg  <= '0;
            end
            ST_IDX_WAIT: begin
                idx_reg <= RA_W'(div_q);
            end
            ST_NORM_START: begin
                ptr_reg   <= CA_W'(32'(idx_reg) * 32'(REC_WORDS));
                oor_reg   <= nneg;
                x_reg     <= '0;
                t_arr[0]  <= Q61_ONE;
                t_arr[1]  <= '0;
                t1_reg    <= '0;
                t2_reg    <= Q61_ONE;
                k_reg     <= KW'(2);
            end
            ST_NORM_WAIT: begin
                if (div_done) begin
                    x_reg    <= oor_reg ? (64'd0 - qsat) : qsat;
                    t_arr[1] <= oor_reg ? (64'd0 - qsat) : qsat;
                    t1_reg   <= oor_reg ? (64'd0 - qsat) : qsat;
                end
            end
            ST_T_MUL: begin
                if (k_reg >= n_reg) begin
                    k_reg   <= '0;
                    a_reg   <= 2'd0;
                    acc_reg <= '0;
                    oor_reg <= 1'b0;
                end
            end
            ST_T_WAIT: begin
                if (mul_done) begin
                    t_arr[k_reg[KI-1:0]] <= tn;
                    t2_reg <= t1_reg;
                    t1_reg <= tn;
                    k_reg  <= k_reg + 1'b1;
                end
            end
            ST_C_WAIT: begin
                if (mul_done) begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (last_k) begin
                        case (a_reg)
                            2'd0:    px_reg <= sum_sat;
                            2'd1:    py_reg <= sum_sat;
                            default: pz_reg <= sum_sat;
                        endcase
                        acc_reg <= '0;
                        k_reg   <= '0;
                        a_reg   <= a_reg + 1'b1;
                    end else begin
                        acc_reg <= sum_v;
                        k_reg   <= k_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {pz_reg, py_reg, px_reg};
            m_user_reg <= oor_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    cee_store #(
        .MAX_COEFF   (MAX_COEFF),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_store (
        .aclk         (aclk),
        .wr           (wr),
        .rec_rd_en    (rec_rd_en),
        .rec_rd_addr  (RA_W'(div_q)),
        .mid_q        (mid_q),
        .half_q       (half_q),
        .coef_rd_en   (coef_rd_en),
        .coef_rd_addr (ptr_reg),
        .coef_q       (coef_q)
    );

    cee_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .steps   (div_steps),
        .divisor (div_divisor),
        .done    (div_done),
        .q       (div_q),
        .big     (div_big)
    );

    cee_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

endmodule

/* tb/chebyshev_ephemeris_evaluator_test.sv */
// self-checking testbench of the chebyshev ephemeris evaluator: record loads, queries,
// register phases, random idling on both streams and one long output back-pressure
// depends on cee_pkg and chebyshev_ephemeris_evaluator
module chebyshev_ephemeris_evaluator_test;
    import cee_pkg::*;

    localparam int NUM_RECORDS = 1024;
    localparam int STORE_WORDS = 48;
    localparam int WORD_LIMIT  = 50;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 900;
    localparam int HOLD_CYCLES = 4000;
    localparam logic signed [127:0] S128_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] S128_LO = -128'sh8000_0000_0000_0000;

    typedef enum bit { OP_LOAD = 1'b0, OP_QUERY = 1'b1 } ephem_op_t;

    typedef struct {
        ephem_op_t   op;
        logic [9:0]  rec;
        logic [5:0]  word;
        logic [63:0] value;
        logic [63:0] qtime;
    } ephem_req_t;

    typedef struct {
        logic [63:0] px;
        logic [63:0] py;
        logic [63:0] pz;
        logic        oor;
    } position_t;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [191:0] m_tdata;
    logic         m_tuser;

    chebyshev_ephemeris_evaluator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // shadow of the record tables and registers
    logic [63:0] coef_mem [NUM_RECORDS][STORE_WORDS];
    logic [63:0] mid_mem  [NUM_RECORDS];
    logic [63:0] half_mem [NUM_RECORDS];
    logic [49:0] written  [NUM_RECORDS];
    int          loaded_recs [$];
    logic [63:0] start_q;
    logic [62:0] span_q;
    logic [4:0]  ncoef_q;
    logic [10:0] nrec_q;

    ephem_req_t pending_reqs [$];
    position_t  expected_pos [$];
    int  made_cnt, taken_cnt, result_cnt, flagged_cnt, errors;
    bit  send_idle, recv_stall;
    int  idle_pct;
    int  hold_left;

    function automatic logic signed [127:0] sx(input logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic logic [63:0] clamp64(input logic signed [127:0] v);
        if (v > S128_HI) return S64_MAX;
        if (v < S128_LO) return S64_MIN;
        return v[63:0];
    endfunction

    function automatic logic signed [127:0] term(input logic [63:0] c, input logic [63:0] tk);
        return (sx(c) * sx(tk)) >>> 61;
    endfunction

    // (t - mid) / half in Q2.61, truncated toward zero and saturated
    function automatic logic [63:0] norm_time(input logic [63:0] t, input logic [63:0] mid,
                                              input logic [63:0] half);
        logic signed [127:0] d;
        logic [127:0] mag;
        logic [191:0] q;
        logic [63:0]  h, lim;
        logic         neg;
        d   = sx(t) - sx(mid);
        neg = d[127] ^ half[63];
        h   = half[63] ? -half : half;
        if (h == 0) return '0;
        mag = d[127] ? -d : d;
        q   = ({64'd0, mag} << 61) / {128'd0, h};
        lim = neg ? S64_MIN : S64_MAX;
        if (q > {128'd0, lim}) q = {128'd0, lim};
        return neg ? -q[63:0] : q[63:0];
    endfunction

    // chebyshev sum of one axis of one record
    function automatic logic [63:0] axis_sum(input int r, input int a, input int n,
                                             input logic [63:0] x);
        logic signed [127:0] acc;
        logic [63:0] t2, t1, tn;
        t2  = Q61_ONE;
        t1  = x;
        acc = term(coef_mem[r][a*n], t2) + term(coef_mem[r][a*n+1], t1);
        for (int k = 2; k < n; k++) begin
            tn  = clamp64(((sx(x) * sx(t1)) >>> 60) - sx(t2));
            acc = acc + term(coef_mem[r][a*n+k], tn);
            t2  = t1;
            t1  = tn;
        end
        return clamp64(acc);
    endfunction

    // record selected by a query time; flagged when outside the configured record range
    function automatic void locate(input logic [63:0] t, output int idx, output bit flagged);
        logic signed [127:0] d;
        logic [63:0] q;
        int bound;
        d       = sx(t) - sx(start_q);
        bound   = (nrec_q < NUM_RECORDS) ? nrec_q : NUM_RECORDS;
        flagged = 1'b1;
        idx     = 0;
        if (d < 0 || span_q == 0) return;
        q = d[63:0] / {1'b0, span_q};
        if (q >= bound) return;
        idx     = q;
        flagged = 1'b0;
    endfunction

    function automatic bit reads_written(input logic [63:0] t);
        int  idx;
        bit  flagged;
        locate(t, idx, flagged);
        return flagged || (&written[idx]);
    endfunction

    // update the shadow tables and queue the expected position
    task automatic post_item(input ephem_req_t rq);
        position_t p;
        int idx, n;
        bit flagged;
        if (rq.op == OP_LOAD) begin
            if (rq.word == 0) mid_mem[rq.rec] = rq.value;
            else if (rq.word == 1) half_mem[rq.rec] = rq.value;
            else if (rq.word < WORD_LIMIT) coef_mem[rq.rec][rq.word-2] = rq.value;
            if (rq.word < WORD_LIMIT) begin
                written[rq.rec][rq.word] = 1'b1;
                if (&written[rq.rec] && !(rq.rec inside {loaded_recs}))
                    loaded_recs.push_back(rq.rec);
            end
        end else begin
            p = '{px: '0, py: '0, pz: '0, oor: 1'b1};
            locate(rq.qtime, idx, flagged);
            if (!flagged) begin
                n     = (ncoef_q < 2) ? 2 : (ncoef_q > 16) ? 16 : ncoef_q;
                p.oor = 1'b0;
                p.px  = axis_sum(idx, 0, n, norm_time(rq.qtime, mid_mem[idx], half_mem[idx]));
                p.py  = axis_sum(idx, 1, n, norm_time(rq.qtime, mid_mem[idx], half_mem[idx]));
                p.pz  = axis_sum(idx, 2, n, norm_time(rq.qtime, mid_mem[idx], half_mem[idx]));
            end else begin
                flagged_cnt++;
            end
            expected_pos.push_back(p);
        end
        pending_reqs.push_back(rq);
        made_cnt++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_word(input int r, input int w, input logic [63:0] v);
        ephem_req_t rq;
        rq = '{op: OP_LOAD, rec: r, word: w, value: v, qtime: rand64()};
        post_item(rq);
    endtask

    // one whole record in file order, midpoint and half span near its time slot
    task automatic load_record(input int r);
        logic [63:0] mid, half, c;
        mid  = start_q + r * {1'b0, span_q} + (span_q >> 1);
        half = {1'b0, span_q} >> 1;
        case ($urandom_range(9))
            0: half = rand64();
            1: half = -half;
            2: half = S64_MIN;
            3: mid  = mid + ($urandom_range(255) - 128);
            default: ;
        endcase
        load_word(r, 0, mid);
        load_word(r, 1, half);
        for (int w = 2; w < WORD_LIMIT; w++) begin
            c = rand64();
            if ($urandom_range(3) != 0) c = $signed(c) >>> $urandom_range(63);
            load_word(r, w, c);
        end
    endtask

    task automatic query_at(input logic [63:0] t);
        ephem_req_t rq;
        rq = '{op: OP_QUERY, rec: $urandom, word: $urandom, value: rand64(), qtime: t};
        post_item(rq);
    endtask

    // query aimed at a loaded record, at a range edge or at a random time
    task automatic random_query();
        logic signed [127:0] tt;
        logic [63:0] t;
        int r;
        case ($urandom_range(9))
            0, 1: t = rand64();
            2: t = start_q - 1;
            3: t = start_q + nrec_q * {1'b0, span_q};
            default: begin
                r  = loaded_recs[$urandom_range(loaded_recs.size() - 1)];
                tt = sx(start_q) + r * {65'd0, span_q} + (rand64() % {1'b0, span_q | 63'd1});
                t  = (tt > S128_HI) ? start_q : tt[63:0];
            end
        endcase
        if (!reads_written(t)) t = start_q;
        query_at(t);
    endtask

    task automatic cfg_write(input cfg_addr_t a, input logic [63:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (a)
            CFG_START_TIME:   start_q = v;
            CFG_RECORD_SPAN:  span_q  = v[62:0];
            CFG_COEFF_COUNT:  ncoef_q = v[4:0];
            CFG_RECORD_COUNT: nrec_q  = v[10:0];
            default: ;
        endcase
    endtask

    // wait for every request to be taken and every result back, then let the core settle
    task automatic drain();
        while (taken_cnt != made_cnt || expected_pos.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin : driver
        ephem_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) taken_cnt++;
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 &&
                    !(send_idle && $urandom_range(99) < idle_pct)) begin
                    rq = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {rq.qtime, rq.value, rq.word, rq.rec};
                    s_tuser  <= rq.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result checker, ready control and watchdog
    always @(posedge aclk) begin : monitor
        position_t p;
        int quiet;
        if (!aresetn) begin
            m_tready <= 1'b0;
            quiet = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (expected_pos.size() == 0) begin
                    $error("position returned with none expected");
                    errors++;
                end else begin
                    p = expected_pos.pop_front();
                    if (m_tdata[63:0] !== p.px) begin
                        $error("pos_x expected %h got %h", p.px, m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[127:64] !== p.py) begin
                        $error("pos_y expected %h got %h", p.py, m_tdata[127:64]);
                        errors++;
                    end
                    if (m_tdata[191:128] !== p.pz) begin
                        $error("pos_z expected %h got %h", p.pz, m_tdata[191:128]);
                        errors++;
                    end
                    if (m_tuser !== p.oor) begin
                        $error("out_of_range expected %b got %b", p.oor, m_tuser);
                        errors++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(recv_stall && $urandom_range(99) < idle_pct);
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        logic [63:0] p_start [8];
        logic [63:0] p_span  [8];
        logic [63:0] p_ncoef [8];
        logic [63:0] p_nrec  [8];
        int r;
        start_q = '0;
        span_q  = 63'd1;
        ncoef_q = 5'd2;
        nrec_q  = 11'd1;
        idle_pct = 73;
        for (int i = 0; i < NUM_RECORDS; i++) written[i] = '0;
        p_start = '{0, 0, S64_MIN, S64_MAX, rand64(), rand64(), -(64'd1000 << 20), rand64()};
        p_span  = '{1, 64'd1 << 20, S64_MAX, 1, $urandom_range(1, 1 << 30), 0, 64'd3 << 20,
                    rand64()};
        p_ncoef = '{2, 16, 2, 17, 0, 31, 7, $urandom_range(2, 16)};
        p_nrec  = '{1, 1024, 1, 2047, 0, 5, 12, $urandom_range(1, 1024)};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero half span, edges of time, ignored words, top record
        load_record(0);
        load_word(1023, 0, S64_MAX);
        load_word(5, 50, rand64());
        load_word(5, 63, rand64());
        query_at(0);
        query_at(-64'sd1);
        query_at(1);
        query_at(S64_MIN);
        query_at(S64_MAX);
        drain();

        for (int ph = 1; ph < 8; ph++) begin
            cfg_write(CFG_START_TIME, p_start[ph]);
            cfg_write(CFG_RECORD_SPAN, p_span[ph]);
            cfg_write(CFG_COEFF_COUNT, p_ncoef[ph]);
            cfg_write(CFG_RECORD_COUNT, p_nrec[ph]);
            send_idle  = ph[0];
            recv_stall = ph[1];
            // lighter idling when both sides pause
            idle_pct   = (ph[0] && ph[1]) ? 36 : 73;
            if (ph == 6) begin
                @(negedge aclk);
                hold_left = HOLD_CYCLES;
            end
            for (int j = 0; j < 2; j++) begin
                case ($urandom_range(4))
                    0: r = 1023;
                    1: r = $urandom_range(1023);
                    default: r = $urandom_range(15);
                endcase
                load_record(r);
                for (int k = 0; k < 18; k++) random_query();
                // noise: lone words, including ignored word indexes
                for (int k = 0; k < 5; k++)
                    load_word($urandom_range(1023), $urandom_range(63), rand64());
            end
            drain();
        end

        $display("covered %0d requests, %0d positions checked, %0d flagged out of range",
                 made_cnt, result_cnt, flagged_cnt);
        if (errors == 0 && expected_pos.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
